/* hw/rtl/bar_level_meter_peak_hold_defines.svh */
// assertion macros for the bar level meter checker
// no dependencies; included by the checker file
`ifndef BAR_LEVEL_METER_PEAK_HOLD_DEFINES_SVH
`define BAR_LEVEL_METER_PEAK_HOLD_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define BLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define BLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define BLM_ASSERT_RST(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/blm_pkg.sv */
// shared types and constants of the bar level meter
// no dependencies
package blm_pkg;

  localparam int CH_W    = 6;
  localparam int LVL_W   = 8;
  localparam int HGT_W   = 8;
  localparam int PROD_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_UPDATES = 2'd1;

  localparam logic [CFG_DAT_W-1:0] FULL_SCALE_RST   = 8'd180;
  localparam logic [CFG_DAT_W-1:0] HOLD_UPDATES_RST = 8'd20;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [LVL_W-1:0] level;
  } blm_in_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel_out;
    logic [HGT_W-1:0] height;
    logic [HGT_W-1:0] peak_level;
  } blm_out_t;

  // one channel's stored state
  typedef struct packed {
    logic [HGT_W-1:0] bar;
    logic [HGT_W-1:0] peak;
    logic [HGT_W-1:0] hold;
  } blm_entry_t;

endpackage

/* hw/rtl/blm_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module blm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/blm_update.sv */
// per-channel update: scale to target, attack/decay smoothing, peak hold
// depends on blm_pkg
module blm_update (
  input  logic [blm_pkg::PROD_W-1:0]    prod,
  input  logic [blm_pkg::CFG_DAT_W-1:0] hold_updates,
  input  blm_pkg::blm_entry_t           cur,
  output blm_pkg::blm_entry_t           upd
);

  logic [blm_pkg::PROD_W-1:0] tsum;
  logic [blm_pkg::HGT_W-1:0]  target;
  logic [blm_pkg::HGT_W-1:0]  gap;
  logic [blm_pkg::HGT_W:0]    step;
  logic [blm_pkg::HGT_W-1:0]  bar_n;

  // exact floor(prod / 255) for a product of two 8 bit values
  assign tsum   = prod + {8'd0, prod[15:8]} + 16'd1;
  assign target = tsum[15:8];

  always_comb begin
    if (target > cur.bar) begin
      gap   = target - cur.bar;
      step  = ({1'b0, gap} + 9'd1) >> 1;
      bar_n = cur.bar + step[blm_pkg::HGT_W-1:0];
    end else begin
      gap   = cur.bar - target;
      step  = ({1'b0, gap} + 9'd3) >> 2;
      bar_n = cur.bar - step[blm_pkg::HGT_W-1:0];
    end
  end

  always_comb begin
    upd.bar  = bar_n;
    upd.peak = cur.peak;
    upd.hold = cur.hold;
    if (bar_n > cur.peak) begin
      upd.peak = bar_n;
      upd.hold = hold_updates;
    end else if (cur.hold != '0) begin
      upd.hold = cur.hold - 8'd1;
    end else if (cur.peak != '0) begin
      upd.peak = cur.peak - 8'd1;
    end
  end

endmodule

/* hw/rtl/bar_level_meter_peak_hold.sv */
// top level of the multi-channel bar level meter with peak hold
// depends on blm_pkg, blm_ram, blm_update
//
// Takes one transaction per cycle while in_stall is low and gives one result per
// transaction, in order, through the update stage and output register. Each
// transaction names a channel and a raw level; the level is scaled by full_scale / 255,
// the channel's bar height moves toward it (up by half the gap, down by a quarter), and
// the peak is held for hold_updates updates before decaying by one per update. Channel
// state (bar, peak, hold count) lives in one memory of CHANNELS entries with a
// registered read; the rate of one update per cycle is set by the single
// read-modify-write of that memory, with the write of the previous transaction forwarded
// when the next one hits the same channel. Per-entry valid bits make every channel read
// as zero after reset, so no clearing pass is needed. A channel at or above CHANNELS
// leaves state alone and reports zero height and peak. Configuration is taken at any
// cycle (cfg_ready is always high) and should only be written while the meter is idle.
module bar_level_meter_peak_hold #(
  parameter int CHANNELS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  blm_pkg::blm_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output blm_pkg::blm_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [blm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blm_pkg::CFG_DAT_W-1:0] cfg_wdata
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [blm_pkg::CH_W:0] CHAN_LIM = (blm_pkg::CH_W + 1)'(CHANNELS);
  localparam int EW = $bits(blm_pkg::blm_entry_t);

  // configuration registers
  logic [blm_pkg::CFG_DAT_W-1:0] full_scale_r;
  logic [blm_pkg::CFG_DAT_W-1:0] hold_updates_r;

  // update stage (memory read data arrives here)
  logic                        s1_vld_r;
  logic [blm_pkg::CH_W-1:0]    s1_ch_r;
  logic                        s1_inr_r;
  logic [blm_pkg::PROD_W-1:0]  s1_prod_r;
  logic                        fwd_hit_r;
  blm_pkg::blm_entry_t         fwd_data_r;

  // per-entry valid bits, an entry never written reads as zero
  logic [CHANNELS-1:0]         valid_r;

  // output register
  logic                        out_vld_r;
  blm_pkg::blm_out_t           out_data_r;
  blm_pkg::blm_out_t           out_data_nxt;

  logic                        in_acc;
  logic                        s1_adv;
  logic                        in_inr;
  logic [blm_pkg::PROD_W-1:0]  prod_nxt;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               s1_addr;
  logic                        wr_en;
  logic [EW-1:0]               ram_rdata;
  blm_pkg::blm_entry_t         cur_entry;
  blm_pkg::blm_entry_t         upd_entry;

  // handshakes: the update stage moves on whenever the output register can take it
  assign s1_adv    = !out_vld_r || !out_stall;
  assign in_stall  = s1_vld_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign in_inr   = {1'b0, in_data.channel} < CHAN_LIM;
  assign rd_addr  = in_data.channel[AW-1:0];
  assign s1_addr  = s1_ch_r[AW-1:0];
  assign prod_nxt = {8'd0, in_data.level} * {8'd0, full_scale_r};
  assign wr_en    = s1_vld_r && s1_adv && s1_inr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r   <= blm_pkg::FULL_SCALE_RST;
      hold_updates_r <= blm_pkg::HOLD_UPDATES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        blm_pkg::REG_FULL_SCALE:   full_scale_r   <= cfg_wdata;
        blm_pkg::REG_HOLD_UPDATES: hold_updates_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  blm_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr),
    .wdata (upd_entry),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // stage 1 capture; the forward flag is taken with the read, since a stall holds both
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ch_r    <= in_data.channel;
      s1_inr_r   <= in_inr;
      s1_prod_r  <= prod_nxt;
      // same channel written on the edge of this read: memory returns the old value
      fwd_hit_r  <= wr_en && (s1_ch_r == in_data.channel);
      fwd_data_r <= upd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[s1_addr] <= 1'b1;
    end
  end

  // pick the freshest copy of the entry
  always_comb begin
    if (fwd_hit_r) begin
      cur_entry = fwd_data_r;
    end else if (valid_r[s1_addr]) begin
      cur_entry = ram_rdata;
    end else begin
      cur_entry = '0;
    end
  end

  blm_update u_update (
    .prod         (s1_prod_r),
    .hold_updates (hold_updates_r),
    .cur          (cur_entry),
    .upd          (upd_entry)
  );

  always_comb begin
    out_data_nxt.channel_out = s1_ch_r;
    if (s1_inr_r) begin
      out_data_nxt.height     = upd_entry.bar;
      out_data_nxt.peak_level = upd_entry.peak;
    end else begin
      // out-of-range channel reports zeros
      out_data_nxt.height     = '0;
      out_data_nxt.peak_level = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_vld_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/blm_checker.sv */
// port-level checks of the bar level meter, bound to the top level
// depends on blm_pkg and bar_level_meter_peak_hold_defines.svh
`include "bar_level_meter_peak_hold_defines.svh"

module blm_checker #(
  parameter int CHANNELS = 32
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input blm_pkg::blm_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input blm_pkg::blm_out_t out_data
);

  localparam logic [blm_pkg::CH_W:0] CHAN_LIM = (blm_pkg::CH_W + 1)'(CHANNELS);

  logic out_oor;
  assign out_oor = {1'b0, out_data.channel_out} >= CHAN_LIM;

  `BLM_ASSERT_RST(a_reset_clears_out, clk, !rst_n, !out_valid, "out_valid after reset")
  `BLM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `BLM_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without output backpressure")
  `BLM_ASSERT_NOW(a_oor_zero, clk, rst_n, out_valid && out_oor, out_data.height == '0 && out_data.peak_level == '0, "out-of-range channel gave nonzero result")

endmodule

bind bar_level_meter_peak_hold blm_checker #(
  .CHANNELS (CHANNELS)
) u_blm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* bench/bar_level_meter_peak_hold_tb.sv */
`timescale 1ns / 1ps
// self-checking bench for the multi-channel bar level meter with peak hold
// depends on blm_pkg and the bar_level_meter_peak_hold rtl
module bar_level_meter_peak_hold_tb;

  localparam int CHANNELS   = 32;
  localparam int IDLE_LIMIT = 2000;  // cycles with no transaction before giving up
  localparam int MAX_SHOWN  = 10;
  localparam int PHASES     = 6;
  localparam int PHASE_ITEMS = 240;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  blm_pkg::blm_in_t              in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  blm_pkg::blm_out_t             out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [blm_pkg::CFG_IDX_W-1:0] cfg_index = blm_pkg::REG_FULL_SCALE;
  logic [blm_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

  bar_level_meter_peak_hold #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // bench copy of the meter: config registers and per-channel state
  logic [blm_pkg::CFG_DAT_W-1:0] scale_reg;
  logic [blm_pkg::CFG_DAT_W-1:0] hold_reg;
  logic [blm_pkg::HGT_W-1:0]     bar_mem  [CHANNELS];
  logic [blm_pkg::HGT_W-1:0]     peak_mem [CHANNELS];
  logic [blm_pkg::HGT_W-1:0]     hold_mem [CHANNELS];

  blm_pkg::blm_in_t  meter_backlog [$];  // transactions waiting for the driver
  blm_pkg::blm_out_t reading_queue [$];  // predicted results, oldest first
  blm_pkg::blm_out_t want_reading;

  int n_queued = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_outside = 0;
  int n_new_peaks = 0;
  int n_decays = 0;
  int n_cfg_writes = 0;
  int n_settings = 0;

  // one meter update: scale the level, smooth the bar, then run the peak hold
  function automatic blm_pkg::blm_out_t next_reading(blm_pkg::blm_in_t txn);
    blm_pkg::blm_out_t r;
    int ch;
    int target;
    int cur;
    r = '0;
    r.channel_out = txn.channel;
    ch = int'(txn.channel);
    // channel past the table: state untouched, zero height and peak
    if (ch >= CHANNELS) begin
      n_outside++;
      return r;
    end
    target = (int'(txn.level) * int'(scale_reg)) / 255;
    cur = int'(bar_mem[ch]);
    // attack: half the gap rounded up; decay: (gap + 3) / 4, zero when equal
    if (target > cur) cur = cur + (target - cur + 1) / 2;
    else cur = cur - (cur - target + 3) / 4;
    bar_mem[ch] = (blm_pkg::HGT_W)'(cur);
    if (bar_mem[ch] > peak_mem[ch]) begin
      peak_mem[ch] = bar_mem[ch];
      hold_mem[ch] = hold_reg;
      n_new_peaks++;
    end else if (hold_mem[ch] != '0) begin
      hold_mem[ch] = hold_mem[ch] - 1'b1;
    end else if (peak_mem[ch] != '0) begin
      peak_mem[ch] = peak_mem[ch] - 1'b1;
      n_decays++;
    end
    r.height = bar_mem[ch];
    r.peak_level = peak_mem[ch];
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver: presents queued transactions, predicts each one as it is taken
  int send_gap  = 0;
  bit send_calm = 1'b0;
  bit send_hold = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        reading_queue.push_back(next_reading(in_data));
        n_accepted++;
      end
      // switch now and then between gappy and back-to-back stretches
      if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
      // a stalled transaction stays put, otherwise load the next one or idle
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (meter_backlog.size() > 0 && !send_hold) begin
          in_data <= meter_backlog.pop_front();
          in_valid <= 1'b1;
          send_gap = send_calm ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each result with the oldest prediction, drives stall
  int stall_left = 0;
  bit recv_calm  = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (reading_queue.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("unexpected result: ch %0d height %0d peak %0d",
                     out_data.channel_out, out_data.height, out_data.peak_level);
        end else begin
          want_reading = reading_queue.pop_front();
          if (out_data.channel_out !== want_reading.channel_out ||
              out_data.height !== want_reading.height ||
              out_data.peak_level !== want_reading.peak_level) begin
            n_errors++;
            if (n_errors <= MAX_SHOWN)
              $display("result %0d: expected ch %0d height %0d peak %0d, got ch %0d height %0d peak %0d",
                       n_results, want_reading.channel_out, want_reading.height,
                       want_reading.peak_level, out_data.channel_out, out_data.height,
                       out_data.peak_level);
          end
        end
      end
      if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = recv_calm ? 0 : idle_len();
      end
    end
  end

  // watchdog: ends the run when nothing moves for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles, %0d results outstanding",
               quiet_cycles, reading_queue.size());
      $display("bar_level_meter_peak_hold: mismatch");
      $finish;
    end
  end

  task automatic push_item(int ch, int lvl);
    blm_pkg::blm_in_t t;
    t.channel = (blm_pkg::CH_W)'(ch);
    t.level = (blm_pkg::LVL_W)'(lvl);
    meter_backlog.push_back(t);
    n_queued++;
  endtask

  // wait until every queued transaction is taken and every result is back
  task automatic wait_drained();
    while (meter_backlog.size() > 0 || in_valid || reading_queue.size() > 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [blm_pkg::CFG_IDX_W-1:0] idx,
                           logic [blm_pkg::CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == blm_pkg::REG_FULL_SCALE) scale_reg = val;
    else if (idx == blm_pkg::REG_HOLD_UPDATES) hold_reg = val;
    n_cfg_writes++;
  endtask

  // new setting only with the meter idle, after the last result is back
  task automatic apply_setting(int fs, int hold);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(blm_pkg::REG_FULL_SCALE, (blm_pkg::CFG_DAT_W)'(fs));
    write_reg(blm_pkg::REG_HOLD_UPDATES, (blm_pkg::CFG_DAT_W)'(hold));
    n_settings++;
    @(negedge clk);
  endtask

  // a run of updates shaped like real program material on one channel,
  // with some stray updates to other channels mixed in
  task automatic add_burst();
    int r;
    int ch;
    int len;
    int shape;
    int lvl;
    r = $urandom_range(0, 99);
    if (r < 70)
      ch = $urandom_range(0, 1) ? $urandom_range(0, 1) : CHANNELS - 1 - $urandom_range(0, 1);
    else if (r < 88)
      ch = $urandom_range(0, CHANNELS - 1);
    else
      ch = $urandom_range(CHANNELS, 63);
    len = $urandom_range(1, 24);
    shape = $urandom_range(0, 3);
    lvl = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      case (shape)
        0: ;                                             // steady tone
        1: lvl = $urandom_range(0, 255);                 // noise
        2: lvl = (i < len / 3) ? 255 : 0;                // hit then silence
        default: begin                                   // slow drift
          lvl = lvl + int'($urandom_range(0, 40)) - 20;
          if (lvl < 0) lvl = 0;
          if (lvl > 255) lvl = 255;
        end
      endcase
      if ($urandom_range(0, 99) < 15)
        push_item($urandom_range(0, 63), $urandom_range(0, 255));
      push_item(ch, lvl);
    end
  endtask

  initial begin
    int quota;
    int fs;
    int hold;
    scale_reg = blm_pkg::FULL_SCALE_RST;
    hold_reg = blm_pkg::HOLD_UPDATES_RST;
    for (int i = 0; i < CHANNELS; i++) begin
      bar_mem[i] = '0;
      peak_mem[i] = '0;
      hold_mem[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset setting, attack from zero, decay, channel edges
    push_item(0, 255);
    push_item(0, 255);
    push_item(0, 255);
    push_item(0, 0);
    push_item(5, 0);    // bar already at target, stays put
    push_item(CHANNELS - 1, 255);
    push_item(CHANNELS, 255);  // first channel past the table
    push_item(63, 255);
    push_item(63, 0);
    push_item(1, 1);
    push_item(1, 254);
    wait_drained();

    // full scale at top, no hold: peak starts falling on the first lower update
    apply_setting(255, 0);
    push_item(2, 255);
    push_item(2, 255);
    push_item(2, 0);
    push_item(2, 0);
    push_item(2, 0);

    // zero full scale: every target is zero, longest hold
    apply_setting(0, 255);
    push_item(0, 255);
    push_item(0, 128);
    push_item(0, 255);
    push_item(2, 255);

    // smallest nonzero full scale, hold of one
    apply_setting(1, 1);
    push_item(4, 255);
    push_item(4, 254);
    push_item(4, 0);
    push_item(4, 0);
    push_item(4, 0);

    // random phases, each under its own setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin fs = 255; hold = 3; end
        1: begin fs = 180; hold = 20; end
        2: begin fs = 1; hold = 0; end
        3: begin fs = $urandom_range(0, 255); hold = 255; end
        default: begin fs = $urandom_range(1, 255); hold = $urandom_range(0, 8); end
      endcase
      apply_setting(fs, hold);
      quota = n_queued + PHASE_ITEMS;
      while (n_queued < quota) add_burst();
      // once mid-stream: hold the sender until every result is back
      if (p == 1) begin
        while (meter_backlog.size() > PHASE_ITEMS / 2) @(negedge clk);
        send_hold = 1'b1;
        while (in_valid || reading_queue.size() > 0) @(negedge clk);
        send_hold = 1'b0;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    n_errors += reading_queue.size();
    $display("covered %0d transactions (%0d past the channel table), %0d results checked",
             n_accepted, n_outside, n_results);
    $display("%0d register writes over %0d settings, %0d new peaks, %0d peak decay steps",
             n_cfg_writes, n_settings, n_new_peaks, n_decays);
    if (n_errors == 0) begin
      $display("bar_level_meter_peak_hold: match");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("bar_level_meter_peak_hold: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/blm_pkg.sv
hw/rtl/blm_ram.sv
hw/rtl/blm_update.sv
hw/rtl/bar_level_meter_peak_hold.sv
hw/rtl/blm_checker.sv
bench/bar_level_meter_peak_hold_tb.sv
